>>> sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// shared codes and constants of the text console cell writer
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int CHAR_WIDTH   = 8;
  localparam int ATTR_WIDTH   = 8;
  localparam int CELL_WIDTH   = CHAR_WIDTH + ATTR_WIDTH;
  localparam int COL_WIDTH    = 7;
  localparam int ROW_WIDTH    = 5;
  localparam int CFG_IDX_WIDTH = 2;

  // command codes
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // overflow modes
  localparam logic MODE_SCROLL = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_OVERFLOW_MODE = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TEXT_ATTR     = 2'd1;

  localparam logic [CHAR_WIDTH-1:0] NEWLINE_CODE    = 8'd10;
  localparam logic [ATTR_WIDTH-1:0] TEXT_ATTR_RESET = 8'd15;

endpackage

>>> sv/tccw_ram.sv
// ----------------------------------------------------------------------------
// tccw_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/text_console_cell_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// text-mode console engine: cell store, cursor, scroll or clear on overflow
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready): one command per transfer. a put stores
//   {text_attribute, char_code} at the cursor and advances it; newline (10)
//   only moves the cursor to the start of the next row. a read returns the
//   cell at read_row/read_col, or 0 when that position is off the screen.
//   output channel (out_valid/out_ready): exactly one result per command,
//   carrying cell_value, the cursor after the command and char_counted.
//   config channel (cfg_valid/cfg_ready): always ready; index 0 selects
//   overflow mode (0 scroll, 1 clear and home), index 1 the attribute byte.
// latency and throughput
//   a put shows its result in the cycle after its transfer; while each result
//   is taken and no pass runs, the next put may follow in the next cycle:
//   one character per cycle. a read waits in the ram read state before its
//   result is registered, then the next command. a put that moves past the
//   last row starts a pass over the cell ram (clear zeroes every cell, scroll
//   copies each row up by one and blanks the last); no command is taken meanwhile.
// reset
//   rst clears the cursor and registers, then a clearing pass over every
//   cell zeroes the ram before the first command is taken.
// stalls
//   results sit in an output register; a new command is taken while the
//   held result is transferred in the same cycle, otherwise it waits.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // command channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   command,
  input  logic [tccw_pkg::CHAR_WIDTH-1:0]        char_code,
  input  logic [tccw_pkg::ROW_WIDTH-1:0]         read_row,
  input  logic [tccw_pkg::COL_WIDTH-1:0]         read_col,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tccw_pkg::CELL_WIDTH-1:0]        cell_value,
  output logic [tccw_pkg::COL_WIDTH-1:0]         cursor_col,
  output logic [tccw_pkg::ROW_WIDTH-1:0]         cursor_row,
  output logic                                   char_counted,
  // configuration channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
  input  logic [tccw_pkg::ATTR_WIDTH-1:0]        cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] COLS_A      = AW'(COLUMNS);
  localparam logic [AW-1:0] LAST_A      = AW'(CELLS - 1);
  localparam logic [AW-1:0] SCROLL_LAST = AW'(CELLS - COLUMNS - 1);
  localparam logic [AW-1:0] BLANK_FIRST = AW'(CELLS - COLUMNS);

  typedef enum logic [2:0] {
    S_CLEAR,   // zero sweep over the whole ram
    S_IDLE,    // take commands
    S_RDWAIT,  // ram read data arrives
    S_SCROLL,  // copy each row up by one
    S_BLANK    // zero the last row
  } state_t;

  state_t state;

  // configuration registers
  logic                            overflow_mode;
  logic [tccw_pkg::ATTR_WIDTH-1:0] text_attr;

  // cursor
  logic [tccw_pkg::COL_WIDTH-1:0]  cur_col;
  logic [tccw_pkg::ROW_WIDTH-1:0]  cur_row;

  // sweep control
  logic [AW-1:0] cnt;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          rd_oor;

  // ram ports
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [tccw_pkg::CELL_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [tccw_pkg::CELL_WIDTH-1:0] ram_rdata;

  // put step
  logic                            in_xfer;
  logic                            is_put;
  logic                            is_nl;
  logic [tccw_pkg::COL_WIDTH:0]    col_inc;
  logic [tccw_pkg::ROW_WIDTH:0]    row_inc;
  logic                            wrap;
  logic                            last_row;
  logic [tccw_pkg::COL_WIDTH-1:0]  col_next;
  logic [tccw_pkg::ROW_WIDTH-1:0]  row_next;
  logic [AW-1:0]                   cur_addr;
  logic [AW-1:0]                   rd_addr;
  logic                            rd_in_range;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_xfer   = in_valid && in_ready;
  assign is_put    = (command == tccw_pkg::CMD_PUT);
  assign is_nl     = (char_code == tccw_pkg::NEWLINE_CODE);

  // cursor advance
  always_comb begin
    col_inc  = {1'b0, cur_col} + 1'b1;
    row_inc  = {1'b0, cur_row} + 1'b1;
    wrap     = is_nl || (col_inc >= (tccw_pkg::COL_WIDTH + 1)'(COLUMNS));
    last_row = (row_inc >= (tccw_pkg::ROW_WIDTH + 1)'(ROWS));
    col_next = wrap ? '0 : col_inc[tccw_pkg::COL_WIDTH-1:0];
    if (!wrap) begin
      row_next = cur_row;
    end else if (!last_row) begin
      row_next = row_inc[tccw_pkg::ROW_WIDTH-1:0];
    end else if (overflow_mode == tccw_pkg::MODE_SCROLL) begin
      row_next = tccw_pkg::ROW_WIDTH'(ROWS - 1);
    end else begin
      row_next = '0;
    end
  end

  // linear addresses: row times a constant plus column
  assign cur_addr    = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign rd_addr     = AW'(read_row) * COLS_A + AW'(read_col);
  assign rd_in_range = ({1'b0, read_row} < (tccw_pkg::ROW_WIDTH + 1)'(ROWS))
                    && ({1'b0, read_col} < (tccw_pkg::COL_WIDTH + 1)'(COLUMNS));

  // ram port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {text_attr, char_code};
    ram_raddr = rd_addr;
    unique case (state)
      S_IDLE: begin
        ram_we = in_xfer && is_put && !is_nl;
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
      end
      S_SCROLL: begin
        // read one row ahead, write the data of the previous cycle
        ram_raddr = cnt + COLS_A;
        ram_we    = pend;
        ram_waddr = pend_addr;
        ram_wdata = ram_rdata;
      end
      S_BLANK: begin
        // finish the last pending copy before blanking
        ram_we    = 1'b1;
        ram_waddr = pend ? pend_addr : cnt;
        ram_wdata = pend ? ram_rdata : '0;
      end
      S_RDWAIT: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tccw_ram #(
    .WIDTH (tccw_pkg::CELL_WIDTH),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_mode <= tccw_pkg::MODE_SCROLL;
      text_attr     <= tccw_pkg::TEXT_ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tccw_pkg::REG_OVERFLOW_MODE: overflow_mode <= cfg_data[0];
        tccw_pkg::REG_TEXT_ATTR:     text_attr     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer, cursor and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a put taken in the same cycle loads the next result instead
      if (out_valid && out_ready && !(in_xfer && is_put)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST_A) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (is_put) begin
              cur_col      <= col_next;
              cur_row      <= row_next;
              out_valid    <= 1'b1;
              cell_value   <= '0;
              cursor_col   <= col_next;
              cursor_row   <= row_next;
              char_counted <= !is_nl;
              cnt          <= '0;
              if (wrap && last_row) begin
                state <= (overflow_mode == tccw_pkg::MODE_SCROLL) ? S_SCROLL : S_CLEAR;
              end
            end else begin
              rd_oor <= !rd_in_range;
              state  <= S_RDWAIT;
            end
          end
        end
        S_RDWAIT: begin
          out_valid    <= 1'b1;
          cell_value   <= rd_oor ? '0 : ram_rdata;
          cursor_col   <= cur_col;
          cursor_row   <= cur_row;
          char_counted <= 1'b0;
          state        <= S_IDLE;
        end
        S_SCROLL: begin
          pend      <= 1'b1;
          pend_addr <= cnt;
          if (cnt == SCROLL_LAST) begin
            cnt   <= BLANK_FIRST;
            state <= S_BLANK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_BLANK: begin
          if (pend) begin
            pend <= 1'b0;
          end else if (cnt == LAST_A) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/tccw_checker.sv
// ----------------------------------------------------------------------------
// tccw_checker
// port-level checks of the text console cell writer, bound to the top level
// ----------------------------------------------------------------------------
module tccw_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                command,
  input logic [tccw_pkg::CHAR_WIDTH-1:0]     char_code,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [tccw_pkg::CELL_WIDTH-1:0]     cell_value,
  input logic [tccw_pkg::COL_WIDTH-1:0]      cursor_col,
  input logic [tccw_pkg::ROW_WIDTH-1:0]      cursor_row,
  input logic                                char_counted
);

  logic put_xfer;
  logic read_xfer;

  assign put_xfer  = in_valid && in_ready && (command == tccw_pkg::CMD_PUT);
  assign read_xfer = in_valid && in_ready && (command == tccw_pkg::CMD_READ);

  // a held result does not change until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_value)
      && $stable(cursor_col) && $stable(cursor_row) && $stable(char_counted))
    else $error("result changed while stalled");

  // a put posts its result in the next cycle with a zero cell value
  a_put_result: assert property (@(posedge clk) disable iff (rst)
    put_xfer |=> out_valid && (cell_value == '0))
    else $error("put result missing or cell value not zero");

  // newline moves to column zero and is never counted
  a_newline: assert property (@(posedge clk) disable iff (rst)
    put_xfer && (char_code == tccw_pkg::NEWLINE_CODE)
      |=> !char_counted && (cursor_col == '0))
    else $error("newline counted or cursor not at column zero");

  // printable put is counted
  a_printable: assert property (@(posedge clk) disable iff (rst)
    put_xfer && (char_code != tccw_pkg::NEWLINE_CODE) |=> char_counted)
    else $error("printable character not counted");

  // no result is held while the ram read data is awaited, then the read result is posted uncounted
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    read_xfer |=> !out_valid ##1 (out_valid && !char_counted))
    else $error("read result timing wrong");

endmodule

bind text_console_cell_writer_unit tccw_checker u_tccw_checker (.*);

>>> bench/text_console_cell_writer_unit_test.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit_test
// self-checking bench for the text console cell writer
// ----------------------------------------------------------------------------
// a shadow console (cell array, cursor, overflow mode, attribute) predicts the
// result of every accepted command: the cell read back, the cursor after the
// command and whether a character was stored. results are checked in order
// against the queue of predictions. directed tests cover reset contents,
// extreme characters, newline, off-screen reads and every register, then
// random text streams drive the console through row wraps, scrolls and
// clears, with random sender bursts, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module text_console_cell_writer_unit_test;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int SCREEN_CELLS = ROWS * COLUMNS;
  // a hang is caught long after any correct run would have ended, even one
  // where every command moved past the last row and waited out a full pass
  localparam int CYCLE_LIMIT = 8_000_000;
  // idle time before touching registers: longer than the slowest ram pass
  localparam int QUIET_CYCLES = SCREEN_CELLS + 16;

  typedef logic [tccw_pkg::CHAR_WIDTH-1:0]    char_t;
  typedef logic [tccw_pkg::ATTR_WIDTH-1:0]    attr_t;
  typedef logic [tccw_pkg::CELL_WIDTH-1:0]    cell_t;
  typedef logic [tccw_pkg::ROW_WIDTH-1:0]     row_t;
  typedef logic [tccw_pkg::COL_WIDTH-1:0]     col_t;
  typedef logic [tccw_pkg::CFG_IDX_WIDTH-1:0] idx_t;

  // register indexes that map to nothing in the block
  localparam idx_t REG_SPARE_LO = 2'd2;
  localparam idx_t REG_SPARE_HI = 2'd3;

  // receiver stall styles
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_SPARSE} rx_style_t;

  typedef struct packed {
    cell_t cell_data;
    col_t  col;
    row_t  row;
    logic  counted;
  } cmd_result_t;

  // dut ports, every input known from time zero
  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  command = tccw_pkg::CMD_PUT;
  char_t char_code = '0;
  row_t  read_row = '0;
  col_t  read_col = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  cell_t cell_value;
  col_t  cursor_col;
  row_t  cursor_row;
  logic  char_counted;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  idx_t  cfg_index = '0;
  attr_t cfg_data = '0;

  // shadow console state
  cell_t screen_model [SCREEN_CELLS];
  int    cur_col;
  int    cur_row;
  logic  mode_reg;
  attr_t attr_reg;

  // predictions waiting for their result transfer
  cmd_result_t results_due [$];
  cmd_result_t head_result;

  int mismatches = 0;
  int cycles = 0;

  // sender burst state
  int burst_left = 0;
  bit sender_steady = 1'b0;

  // receiver state: hold_request is set by a test, taken by the receiver
  int        hold_request = 0;
  int        hold_left = 0;
  int        style_left = 0;
  int        pattern_step = 0;
  rx_style_t rx_style = RX_OPEN;

  text_console_cell_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .char_code(char_code),
    .read_row(read_row),
    .read_col(read_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_value(cell_value),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row),
    .char_counted(char_counted),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // shadow console
  // ---------------------------------------------------------------------------

  // cursor to the start of the next row; past the bottom either scroll the
  // whole screen up one row or wipe it and home the cursor
  function automatic void next_line();
    int i;
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      if (mode_reg == tccw_pkg::MODE_SCROLL) begin
        cur_row = ROWS - 1;
        for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
          screen_model[i] = screen_model[i + COLUMNS];
        for (i = (ROWS - 1) * COLUMNS; i < SCREEN_CELLS; i++)
          screen_model[i] = '0;
      end else begin
        cur_row = 0;
        for (i = 0; i < SCREEN_CELLS; i++)
          screen_model[i] = '0;
      end
    end
  endfunction

  // applies one command to the shadow console and returns its result
  function automatic cmd_result_t console_step(logic cmd, char_t code, row_t rrow,
                                                col_t rcol);
    cmd_result_t res;
    res.cell_data = '0;
    res.counted   = 1'b0;
    if (cmd == tccw_pkg::CMD_READ) begin
      // off-screen reads give zero
      if (rrow < ROWS && rcol < COLUMNS)
        res.cell_data = screen_model[rrow * COLUMNS + rcol];
    end else if (code == tccw_pkg::NEWLINE_CODE) begin
      // newline is never stored, only the cursor moves
      next_line();
    end else begin
      screen_model[cur_row * COLUMNS + cur_col] = {attr_reg, code};
      res.counted = 1'b1;
      cur_col++;
      if (cur_col >= COLUMNS)
        next_line();
    end
    res.col = cur_col[tccw_pkg::COL_WIDTH-1:0];
    res.row = cur_row[tccw_pkg::ROW_WIDTH-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  task automatic report_field(string name, cell_t want, cell_t got);
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: result transfer expected nothing, actual cell %0h row %0d col %0d",
                 $time, cell_value, cursor_row, cursor_col);
        mismatches++;
      end else begin
        head_result = results_due.pop_front();
        if (cell_value !== head_result.cell_data)
          report_field("cell_value", head_result.cell_data, cell_value);
        if (cursor_col !== head_result.col)
          report_field("cursor_col", cell_t'(head_result.col), cell_t'(cursor_col));
        if (cursor_row !== head_result.row)
          report_field("cursor_row", cell_t'(head_result.row), cell_t'(cursor_row));
        if (char_counted !== head_result.counted)
          report_field("char_counted", cell_t'(head_result.counted), cell_t'(char_counted));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: rotating stall styles, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pattern_step++;
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      // block keeps its one result and has to refuse new commands
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        rx_style = rx_style_t'($urandom_range(3));
        style_left = $urandom_range(40, 200);
      end
      style_left--;
      case (rx_style)
        RX_OPEN:    out_ready <= 1'b1;
        RX_COIN:    out_ready <= ($urandom_range(1) == 1);
        RX_PATTERN: out_ready <= (pattern_step % 4 != 3);
        default:    out_ready <= ($urandom_range(3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offers one command and predicts its result at the transfer; valid stays
  // high into the next command unless a gap ends the burst
  task automatic offer_command(logic cmd, char_t code, row_t rrow, col_t rcol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_steady ? 0 :
            ($urandom_range(9) == 0 ? $urandom_range(8, 30) : $urandom_range(0, 6));
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    command   <= cmd;
    char_code <= code;
    read_row  <= rrow;
    read_col  <= rcol;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(console_step(cmd, code, rrow, rcol));
  endtask

  // unused fields carry random values so the block must ignore them
  task automatic send_put(char_t code);
    offer_command(tccw_pkg::CMD_PUT, code, row_t'($urandom), col_t'($urandom));
  endtask

  task automatic send_read(row_t rrow, col_t rcol);
    offer_command(tccw_pkg::CMD_READ, char_t'($urandom), rrow, rcol);
  endtask

  // drop valid, let every result drain, then wait out any scroll or clear pass
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(idx_t idx, attr_t data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == tccw_pkg::REG_OVERFLOW_MODE)
      mode_reg = data[0];
    else if (idx == tccw_pkg::REG_TEXT_ATTR)
      attr_reg = data;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly anywhere on screen, often just behind the cursor where text was
  // last written, sometimes off the bottom or the right edge
  task automatic send_random_read();
    int pick;
    int r;
    pick = $urandom_range(9);
    if (pick < 5) begin
      send_read(row_t'($urandom_range(ROWS - 1)), col_t'($urandom_range(COLUMNS - 1)));
    end else if (pick < 8) begin
      r = cur_row - int'($urandom_range(0, 2));
      if (r < 0) r = 0;
      send_read(row_t'(r), col_t'($urandom_range(COLUMNS - 1)));
    end else if (pick == 8) begin
      send_read(row_t'($urandom_range(ROWS, 31)), col_t'($urandom_range(127)));
    end else begin
      send_read(row_t'($urandom_range(31)), col_t'($urandom_range(COLUMNS, 127)));
    end
  endtask

  // short lines so the cursor reaches the bottom often, rarely one long
  // enough to wrap past the right edge
  function automatic int pick_line_len();
    if ($urandom_range(23) == 0)
      return $urandom_range(COLUMNS, COLUMNS + 20);
    return $urandom_range(0, 4);
  endfunction

  // lines of random text ended by newlines, reads mixed in
  task automatic run_text_stream(int count, int read_pct);
    int line_left;
    int k;
    line_left = pick_line_len();
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < read_pct) begin
        send_random_read();
      end else if (line_left == 0) begin
        send_put(tccw_pkg::NEWLINE_CODE);
        line_left = pick_line_len();
      end else begin
        send_put(char_t'($urandom_range(255)));
        line_left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the store comes out of reset blank
  task automatic test_reset_contents();
    send_read(row_t'(0), col_t'(0));
    send_read(row_t'(ROWS - 1), col_t'(COLUMNS - 1));
    send_read(row_t'(12), col_t'(40));
  endtask

  // extreme characters with the reset attribute, then newline
  task automatic test_put_extremes();
    send_put(8'h00);
    send_put(8'hFF);
    send_put(8'h41);
    send_put(tccw_pkg::NEWLINE_CODE);
    send_put(8'h7E);
    send_read(row_t'(0), col_t'(0));
    send_read(row_t'(0), col_t'(1));
    send_read(row_t'(0), col_t'(3));
    send_read(row_t'(1), col_t'(0));
  endtask

  // positions just past the screen and the far corners of the fields
  task automatic test_read_out_of_range();
    send_read(row_t'(ROWS), col_t'(0));
    send_read(row_t'(31), col_t'(127));
    send_read(row_t'(0), col_t'(COLUMNS));
    send_read(row_t'(ROWS - 1), col_t'(127));
  endtask

  // attribute extremes, writes to unmapped indexes, and the mode register
  // taking only its low bit
  task automatic test_config_registers();
    write_reg(tccw_pkg::REG_TEXT_ATTR, 8'h00);
    send_put(8'h55);
    write_reg(tccw_pkg::REG_TEXT_ATTR, 8'hFF);
    send_put(8'hAA);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    send_put(8'h33);
    write_reg(tccw_pkg::REG_OVERFLOW_MODE, 8'hFE);
    send_read(row_t'(1), col_t'(1));
    send_read(row_t'(1), col_t'(2));
    send_read(row_t'(1), col_t'(3));
  endtask

  // enough lines to hit the bottom and keep scrolling
  task automatic test_scroll_overflow();
    write_reg(tccw_pkg::REG_OVERFLOW_MODE, 8'hFE);
    write_reg(tccw_pkg::REG_TEXT_ATTR, attr_t'($urandom_range(255)));
    run_text_stream(220, 15);
  endtask

  // receiver refuses for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    settle();
    sender_steady = 1'b1;
    hold_request = 400;
    run_text_stream(30, 10);
    sender_steady = 1'b0;
  endtask

  // clear mode: lines run down the screen and wipe it at the bottom
  task automatic test_clear_overflow();
    write_reg(tccw_pkg::REG_OVERFLOW_MODE, 8'h01);
    write_reg(tccw_pkg::REG_TEXT_ATTR, attr_t'($urandom_range(255)));
    run_text_stream(280, 15);
  endtask

  // fully random commands in chunks, random register writes in between
  task automatic test_random_noise();
    int chunk;
    int k;
    for (chunk = 0; chunk < 4; chunk++) begin
      write_reg(idx_t'($urandom_range(3)), attr_t'($urandom));
      write_reg(tccw_pkg::REG_OVERFLOW_MODE, attr_t'($urandom));
      for (k = 0; k < 25; k++)
        offer_command(($urandom_range(1) == 1), char_t'($urandom), row_t'($urandom),
                      col_t'($urandom));
    end
  endtask

  initial begin
    foreach (screen_model[i]) screen_model[i] = '0;
    cur_col  = 0;
    cur_row  = 0;
    mode_reg = tccw_pkg::MODE_SCROLL;
    attr_reg = tccw_pkg::TEXT_ATTR_RESET;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_contents();
    test_put_extremes();
    test_read_out_of_range();
    test_config_registers();
    test_scroll_overflow();
    test_backpressure();
    test_clear_overflow();
    test_random_noise();

    settle();
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
